// ===== rtl/core/interval_union_merger_assert.svh =====
// assertion macros for the interval union merger
// used by the top level only, no other dependencies
`ifndef INTERVAL_UNION_MERGER_ASSERT_SVH
`define INTERVAL_UNION_MERGER_ASSERT_SVH

`ifndef SYNTH
`define IUM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");
`define IUM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define IUM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IUM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/ium_pkg.sv =====
// shared types and constants for the interval union merger
// no dependencies
package ium_pkg;

  localparam int MAX_SEGS  = 32;
  localparam int POS_WIDTH = 16;

  typedef logic signed [POS_WIDTH-1:0] pos_t;

  typedef struct packed {
    pos_t seg_start;
    pos_t seg_stop;
    logic final_segment;
  } in_word_t;

  typedef struct packed {
    pos_t merged_start;
    pos_t merged_stop;
    logic final_merged;
    logic dropped_any;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // word accepted
    logic last;   // accepted word closes the set
    logic step;   // one sweep step
    logic flush;  // hand the held result on as the last one
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ends_left;
    logic stall;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/ium_sort_cells.sv =====
// row of sorting cells: ascending insertion on load, shift towards the head on pop
// depends on ium_pkg
module ium_sort_cells #(
  parameter int DEPTH = ium_pkg::MAX_SEGS,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           ins_i,
  input  ium_pkg::pos_t  ins_val_i,
  input  logic [CW-1:0]  fill_i,
  input  logic           pop_i,
  output ium_pkg::pos_t  head_o
);

  ium_pkg::pos_t cell_q [DEPTH];
  logic [DEPTH-1:0] place;

  // place[i]: new value belongs at or below cell i
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) < fill_i) begin
        place[i] = cell_q[i] > ins_val_i;
      end else begin
        place[i] = 1'b1;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ins_i) begin
        if (g > 0 && place[(g > 0) ? g - 1 : 0]) begin
          cell_q[g] <= cell_q[(g > 0) ? g - 1 : 0];
        end else if (place[g]) begin
          cell_q[g] <= ins_val_i;
        end
      end else if (pop_i && g < DEPTH - 1) begin
        cell_q[g] <= cell_q[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  assign head_o = cell_q[0];

endmodule

// ===== rtl/core/ium_datapath.sv =====
// datapath: segment stores, fill count, sweep counters and result registers
// depends on ium_pkg and ium_sort_cells
module ium_datapath #(
  parameter int MAX_SEGS = ium_pkg::MAX_SEGS,
  localparam int CW = $clog2(MAX_SEGS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ium_pkg::cmd_t      cmd_i,
  input  ium_pkg::in_word_t  in_word_i,
  output ium_pkg::status_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ium_pkg::out_word_t out_word_o
);

  localparam logic [CW-1:0]    FULL = CW'(MAX_SEGS);
  localparam logic [CW-1:0]    DEC  = CW'(1);
  localparam logic signed [CW:0] ONE = (CW + 1)'(1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] bcnt_q, bcnt_d, ecnt_q, ecnt_d;
  logic ovf_q, ovf_d, drop_q, drop_d;
  logic signed [CW:0] open_q, open_d;
  ium_pkg::pos_t run_q, run_d;
  logic pend_valid_q, pend_valid_d;
  ium_pkg::pos_t pend_start_q, pend_start_d, pend_stop_q, pend_stop_d;
  logic out_valid_q, out_valid_d;
  ium_pkg::out_word_t out_q, out_d;

  logic ins, take_begin, emit, out_free, pop_b, pop_e;
  ium_pkg::pos_t bhead, ehead;

  assign ins = cmd_i.load && (count_q != FULL);

  ium_sort_cells #(.DEPTH(MAX_SEGS)) u_begins (
    .clk_i     (clk_i),
    .ins_i     (ins),
    .ins_val_i (in_word_i.seg_start),
    .fill_i    (count_q),
    .pop_i     (pop_b),
    .head_o    (bhead)
  );

  ium_sort_cells #(.DEPTH(MAX_SEGS)) u_ends (
    .clk_i     (clk_i),
    .ins_i     (ins),
    .ins_val_i (in_word_i.seg_stop),
    .fill_i    (count_q),
    .pop_i     (pop_e),
    .head_o    (ehead)
  );

  // a begin goes first on a tie, so touching segments join
  assign take_begin = (bcnt_q != '0) && (bhead <= ehead);
  assign emit       = !take_begin && (open_q == ONE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign pop_b      = cmd_i.step && take_begin;
  assign pop_e      = cmd_i.step && !take_begin;

  assign sts_o.ends_left  = ecnt_q != '0;
  assign sts_o.stall      = emit && pend_valid_q && !out_free;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

  always_comb begin
    count_d      = count_q;
    ovf_d        = ovf_q;
    drop_d       = drop_q;
    bcnt_d       = bcnt_q;
    ecnt_d       = ecnt_q;
    open_d       = open_q;
    run_d        = run_q;
    pend_valid_d = pend_valid_q;
    pend_start_d = pend_start_q;
    pend_stop_d  = pend_stop_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (cmd_i.load) begin
      if (ins) begin
        count_d = count_q + DEC;
      end else begin
        ovf_d = 1'b1;
      end
      if (cmd_i.last) begin
        bcnt_d  = count_d;
        ecnt_d  = count_d;
        drop_d  = ovf_d;
        open_d  = '0;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end

    if (cmd_i.step) begin
      if (take_begin) begin
        open_d = open_q + ONE;
        if (open_q == '0) begin
          run_d = bhead;
        end
        bcnt_d = bcnt_q - DEC;
      end else begin
        open_d = open_q - ONE;
        ecnt_d = ecnt_q - DEC;
        if (emit) begin
          // the held result is now known not to be the last
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d = '{merged_start: pend_start_q, merged_stop: pend_stop_q,
                      final_merged: 1'b0, dropped_any: drop_q};
          end
          pend_valid_d = 1'b1;
          pend_start_d = run_q;
          pend_stop_d  = ehead;
        end
      end
    end

    if (cmd_i.flush) begin
      out_valid_d  = 1'b1;
      out_d = '{merged_start: pend_start_q, merged_stop: pend_stop_q,
                final_merged: 1'b1, dropped_any: drop_q};
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      bcnt_q       <= '0;
      ecnt_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      bcnt_q       <= bcnt_d;
      ecnt_q       <= ecnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q       <= drop_d;
    open_q       <= open_d;
    run_q        <= run_d;
    pend_start_q <= pend_start_d;
    pend_stop_q  <= pend_stop_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/ium_ctrl.sv =====
// controller: load, sweep and flush phases of one set
// depends on ium_pkg
module ium_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  ium_pkg::status_t sts_i,
  output ium_pkg::cmd_t    cmd_o
);

  ium_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ium_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = ium_pkg::ST_SWEEP;
        end
      end
      ium_pkg::ST_SWEEP: begin
        if (!sts_i.ends_left) begin
          state_d = ium_pkg::ST_FLUSH;
        end
      end
      ium_pkg::ST_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          state_d = ium_pkg::ST_LOAD;
        end
      end
      default: state_d = ium_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ium_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        cmd_o.last = in_valid_i && in_last_i;
      end
      ium_pkg::ST_SWEEP: begin
        cmd_o.step = sts_i.ends_left && !sts_i.stall;
      end
      ium_pkg::ST_FLUSH: begin
        cmd_o.flush = sts_i.pend_valid && sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ium_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/interval_union_merger.sv =====
// interval union merger: one word per cycle while a set loads; after the last word
// the sweep visits each stored begin and end in ascending order (at most 2n for n stored segments),
// then leaves the sweep and hands on the last merged segment, with input held off
// throughout. results leave through an output register, so output stalls only pause
// the sweep and the hand-off.
// reset (async, active low) empties the store and flag and returns to loading.
`include "interval_union_merger_assert.svh"
module interval_union_merger #(
  parameter int MAX_SEGS = ium_pkg::MAX_SEGS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ium_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ium_pkg::out_word_t out_word_o
);

  ium_pkg::cmd_t    cmd;
  ium_pkg::status_t sts;

  ium_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.final_segment),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ium_datapath #(.MAX_SEGS(MAX_SEGS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `IUM_ASSERT_IMP(a_load_idle, clk_i, rst_ni, in_ready_o, !sts.ends_left)
  `IUM_ASSERT_IMP(a_step_work, clk_i, rst_ni, cmd.step, sts.ends_left && !in_ready_o)
  `IUM_ASSERT_IMP(a_flush_room, clk_i, rst_ni, cmd.flush, sts.pend_valid && sts.out_free)
  `IUM_ASSERT_NEXT(a_last_holds, clk_i, rst_ni,
                   in_valid_i && in_ready_o && in_word_i.final_segment, !in_ready_o)

endmodule
